// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while the block is out of reset
`define CCRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define CCRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ccrc_pkg.sv
// ----------------------------------------------------------------------------
// ccrc_pkg
// Widths, constants and shared types of the congestion rate controller.
// ----------------------------------------------------------------------------
package ccrc_pkg;

    // Field widths
    localparam int SEEN_W  = 12;
    localparam int OWN_W   = 12;
    localparam int PEER_W  = 8;
    localparam int TGT_W   = 10;
    localparam int TOTAL_W = 13;
    localparam int IV_W    = 16;
    localparam int JIT_W   = 14;
    localparam int MIN_W   = 12;

    // Serial divider and multiplier operand widths
    localparam int DVD_W  = TOTAL_W + 8;
    localparam int DVS_W  = TGT_W;
    localparam int MULB_W = DVD_W + 1;
    localparam int PROD_W = IV_W + MULB_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
    localparam logic [TGT_W-1:0]     TGT_RESET   = 10'd16;

    // Interval constants in ms
    localparam logic [IV_W-1:0]  IV_MAX      = 16'd4000;
    localparam logic [IV_W-1:0]  IV_FLOOR    = 16'd150;
    localparam logic [IV_W-1:0]  IV_SILENT   = 16'd1000;
    localparam logic [IV_W-1:0]  IV_ZERO     = 16'd50;
    localparam logic [IV_W-1:0]  TRIM_KNEE   = 16'd300;
    localparam logic [IV_W-1:0]  ADJ_BASE    = 16'd10;
    localparam logic [IV_W-1:0]  ADJ_MID     = 16'd20;
    localparam logic [IV_W-1:0]  ADJ_BIG     = 16'd50;
    localparam logic [IV_W-1:0]  ADJ_FINE    = 16'd3;
    localparam logic [JIT_W-1:0] JIT_MIN     = 14'd25;
    localparam logic [MIN_W-1:0] MIN_NO_PEER = 12'd1000;
    localparam logic [MIN_W-1:0] MIN_SAT     = 12'd4000;
    localparam logic [DVD_W-1:0] MIN_NUM     = 21'd4000;

    // Slow-down offset 0.4 in Q8
    localparam logic [MULB_W-1:0] OFFSET_Q8 = 22'd102;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// File: sv/ccrc_div.sv
// ----------------------------------------------------------------------------
// ccrc_div
// Restoring serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccrc_div import ccrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_unit_stat       o_stat,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_rem_sh;
    logic [DVS_W+1:0] w_diff;
    logic             w_fit;

    // Trial subtract of the shifted remainder
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DVD_W-1]};
        w_diff   = {1'b0, w_rem_sh} - {2'b0, r_dvs};
        w_fit    = !w_diff[DVS_W+1];
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// File: sv/ccrc_mul.sv
// ----------------------------------------------------------------------------
// ccrc_mul
// Shift-add serial multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ccrc_mul import ccrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IV_W-1:0]   i_a,
    input  logic [MULB_W-1:0] i_b,
    output t_unit_stat        o_stat,
    output logic [PROD_W-1:0] o_product
);
    localparam int CNT_W = $clog2(MULB_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [IV_W-1:0]   r_a;
    logic [PROD_W-1:0] r_prod;

    logic [IV_W:0]     w_hi;

    // Add the multiplicand into the upper part when the low bit is set
    always_comb begin
        w_hi = {1'b0, r_prod[PROD_W-1:MULB_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MULB_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Accumulate and shift right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{IV_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {w_hi, r_prod[MULB_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_prod;

endmodule

// File: sv/channel_congestion_rate_control_top.sv
// ----------------------------------------------------------------------------
// channel_congestion_rate_control_top
// Adapts a transmit interval once per evaluation period from traffic counts.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. After the accepting edge the
// sequencer passes S_EVAL, then S_FINISH, which loads the result and raises
// o_valid, for a silent period, a zero target, a halving or an unchanged
// interval; a trim with no active peers adds S_TRIM before S_FINISH. A trim
// whose per-peer share comes out zero needs one pass of the serial divider;
// any other trim needs two divider passes; a slow-down needs one divider pass
// plus one multiplier pass. The divider runs 21 steps and the multiplier 22,
// each retiring one bit per cycle between a registered start and done pulse.
// A result waits in the output register, and o_ready rises as the result is
// loaded there; a result still waiting when the next one is ready stalls
// the block for as long as i_ready stays low.
// Configuration writes are always ready and take effect on the next item.
module channel_congestion_rate_control_top import ccrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TGT_W-1:0]     i_cfg_data,
    // input transaction
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SEEN_W-1:0]    i_seen_count,
    input  logic [OWN_W-1:0]     i_own_count,
    input  logic [PEER_W-1:0]    i_active_peers,
    // result transaction
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [IV_W-1:0]      o_interval_ms,
    output logic [JIT_W-1:0]     o_jitter_ms,
    output logic                 o_reset_radio
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_SHARE,
        S_DIV_MIN,
        S_TRIM,
        S_DIV_RATIO,
        S_MUL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic lt95;
        logic lt25;
        logic lt80;
        logic lt50;
        logic gt90;
        logic gt1;
        logic own_le_seen;
    } t_flags;

    localparam int CMP_W  = 20;
    localparam int GROW_W = PROD_W - 8;

    t_state             r_state;
    logic [TGT_W-1:0]   r_target;
    logic [TGT_W-1:0]   r_nominal;
    logic [SEEN_W-1:0]  r_seen;
    logic [OWN_W-1:0]   r_own;
    logic [PEER_W-1:0]  r_peers;
    logic [TOTAL_W-1:0] r_total;
    logic [IV_W-1:0]    r_iv;
    logic [MIN_W-1:0]   r_min;
    t_flags             r_flags;
    logic [IV_W-1:0]    r_interval;
    logic [1:0]         r_silent;
    logic               r_div_start;
    logic [DVD_W-1:0]   r_div_dvd;
    logic [DVS_W-1:0]   r_div_dvs;
    logic               r_mul_start;
    logic [MULB_W-1:0]  r_mul_b;
    logic               r_o_valid;
    logic [IV_W-1:0]    r_o_interval;
    logic [JIT_W-1:0]   r_o_jitter;
    logic               r_o_reset;

    t_unit_stat         w_div_stat;
    t_unit_stat         w_mul_stat;
    logic [DVD_W-1:0]   w_div_quo;
    logic [PROD_W-1:0]  w_mul_prod;
    logic [CMP_W-1:0]   w_tot;
    logic [CMP_W-1:0]   w_tgt;
    t_flags             w_flags;
    logic [IV_W-1:0]    w_adj;
    logic [IV_W-1:0]    w_trim;
    logic [IV_W-1:0]    w_trim_out;
    logic [GROW_W-1:0]  w_grown;
    logic [IV_W-1:0]    w_grown_iv;
    logic [JIT_W-1:0]   w_jit;
    logic [IV_W-1:0]    w_iv_out;
    logic               w_out_free;

    // Serial arithmetic units
    ccrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    ccrc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_iv),
        .i_b       (r_mul_b),
        .o_stat    (w_mul_stat),
        .o_product (w_mul_prod)
    );

    // Ratio thresholds by cross-multiplication
    always_comb begin
        w_tot               = CMP_W'(r_total);
        w_tgt               = CMP_W'(r_target);
        w_flags.lt95        = (w_tot * 20'd100) < (w_tgt * 20'd95);
        w_flags.lt25        = (w_tot << 2) < w_tgt;
        w_flags.lt80        = (w_tot * 20'd5) < (w_tgt << 2);
        w_flags.lt50        = (w_tot << 1) < w_tgt;
        w_flags.gt90        = (w_tot * 20'd10) > (w_tgt * 20'd9);
        w_flags.gt1         = w_tot > w_tgt;
        w_flags.own_le_seen = r_own <= r_seen;
    end

    // Trim step with per-peer minimum
    always_comb begin
        w_adj = ADJ_BASE;
        if (r_flags.lt80 && (r_iv > TRIM_KNEE)) begin
            w_adj = ADJ_MID;
        end
        if (r_flags.lt50 && (r_iv > TRIM_KNEE)) begin
            w_adj = ADJ_BIG;
        end
        if (r_flags.gt90) begin
            w_adj = ADJ_FINE;
        end
        if (r_flags.own_le_seen) begin
            w_trim = (r_iv > w_adj) ? (r_iv - w_adj) : '0;
        end else begin
            w_trim = r_iv;
        end
        w_trim_out = (w_trim < IV_W'(r_min)) ? IV_W'(r_min) : w_trim;
    end

    // Clamp the slow-down product
    always_comb begin
        w_grown = w_mul_prod[PROD_W-1:8];
        if (w_grown == '0) begin
            w_grown_iv = IV_ZERO;
        end else if (w_grown > GROW_W'(IV_MAX)) begin
            w_grown_iv = IV_MAX;
        end else begin
            w_grown_iv = w_grown[IV_W-1:0];
        end
    end

    // Jitter, floor and output slot
    always_comb begin
        w_jit      = (r_iv[IV_W-1:2] < JIT_MIN) ? JIT_MIN : r_iv[IV_W-1:2];
        w_iv_out   = (r_iv < IV_FLOOR) ? IV_FLOOR : r_iv;
        w_out_free = !r_o_valid || i_ready;
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TGT_RESET;
            r_nominal <= TGT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET:  r_target  <= i_cfg_data;
                REG_NOMINAL: r_nominal <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= IV_SILENT;
            r_silent    <= '0;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            // drop a taken result unless the next one replaces it
            if (r_o_valid && i_ready && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_seen  <= i_seen_count;
                        r_own   <= i_own_count;
                        r_peers <= i_active_peers;
                        r_total <= TOTAL_W'(i_seen_count) + TOTAL_W'(i_own_count);
                        r_iv    <= r_interval;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_flags <= w_flags;
                    if (r_seen == '0) begin
                        r_iv    <= IV_SILENT;
                        r_state <= S_FINISH;
                    end else if (r_target == '0) begin
                        r_state <= S_FINISH;
                    end else if (w_flags.lt95) begin
                        if (w_flags.lt25) begin
                            r_iv    <= r_iv >> 1;
                            r_state <= S_FINISH;
                        end else if (r_peers == '0) begin
                            r_min   <= MIN_NO_PEER;
                            r_state <= S_TRIM;
                        end else begin
                            r_div_dvd   <= DVD_W'(r_nominal);
                            r_div_dvs   <= DVS_W'(r_peers);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_SHARE;
                        end
                    end else if (w_flags.gt1) begin
                        r_div_dvd   <= {r_total, 8'd0};
                        r_div_dvs   <= r_target;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_RATIO;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_DIV_SHARE: begin
                    if (w_div_stat.done) begin
                        if (w_div_quo[DVS_W-1:0] == '0) begin
                            r_min   <= MIN_SAT;
                            r_state <= S_TRIM;
                        end else begin
                            r_div_dvd   <= MIN_NUM;
                            r_div_dvs   <= w_div_quo[DVS_W-1:0];
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_MIN;
                        end
                    end
                end
                S_DIV_MIN: begin
                    if (w_div_stat.done) begin
                        r_min   <= w_div_quo[MIN_W-1:0];
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    r_iv    <= w_trim_out;
                    r_state <= S_FINISH;
                end
                S_DIV_RATIO: begin
                    if (w_div_stat.done) begin
                        r_mul_b     <= {1'b0, w_div_quo} + OFFSET_Q8;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_stat.done) begin
                        r_iv    <= w_grown_iv;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_interval <= w_iv_out;
                        r_o_jitter   <= w_jit;
                        r_interval   <= w_iv_out;
                        if (r_seen != '0) begin
                            r_silent  <= '0;
                            r_o_reset <= 1'b0;
                        end else if (r_silent == 2'd3) begin
                            r_silent  <= '0;
                            r_o_reset <= 1'b1;
                        end else begin
                            r_silent  <= r_silent + 1'b1;
                            r_o_reset <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_interval_ms = r_o_interval;
    assign o_jitter_ms   = r_o_jitter;
    assign o_reset_radio = r_o_reset;

endmodule

// File: sv/ccrc_checker.sv
// ----------------------------------------------------------------------------
// ccrc_checker
// Port-level checks of the congestion rate controller, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [9:0]  i_cfg_data,
    input logic        i_valid,
    input logic        o_ready,
    input logic [11:0] i_seen_count,
    input logic [11:0] i_own_count,
    input logic [7:0]  i_active_peers,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_interval_ms,
    input logic [13:0] o_jitter_ms,
    input logic        o_reset_radio
);

    // Reset leaves no pending result and an idle input side
    `CCRC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_valid && o_ready), "reset not idle")

    // A stalled result stays offered
    `CCRC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")

    // One transaction at a time: busy right after acceptance
    `CCRC_ASSERT(a_one_item, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "second accept")

    // A radio reset comes only from silence, which forces the interval
    `CCRC_ASSERT(a_reset_silent, i_clk, i_rst_n, (o_valid && o_reset_radio) |-> (o_interval_ms == 16'd1000 && o_jitter_ms == 14'd250), "reset without silence")

    // Interval stays between floor and cap
    `CCRC_ASSERT(a_iv_range, i_clk, i_rst_n, o_valid |-> (o_interval_ms >= 16'd150 && o_interval_ms <= 16'd4000), "interval out of range")

endmodule

bind channel_congestion_rate_control_top ccrc_checker u_ccrc_checker (.*);

// File: sim/channel_congestion_rate_control_top_tb.sv
// ----------------------------------------------------------------------------
// channel_congestion_rate_control_top_tb
// Drives evaluation periods into the congestion rate controller and checks
// every interval, jitter and radio-reset result against an in-bench model of
// the interval adaptation or a fixed table value. A directed table runs first
// on the reset settings, then random traffic shaped around the target ratio
// runs under a series of register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module channel_congestion_rate_control_top_tb import ccrc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 60;

    typedef struct packed {
        logic [SEEN_W-1:0] seen;
        logic [OWN_W-1:0]  own;
        logic [PEER_W-1:0] peers;
    } t_traffic;

    typedef struct packed {
        logic [IV_W-1:0]  interval_ms;
        logic [JIT_W-1:0] jitter_ms;
        logic             reset_radio;
    } t_rate_result;

    typedef struct packed {
        t_traffic     traffic;
        logic         fixed;
        t_rate_result want;
    } t_period_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TGT_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [SEEN_W-1:0]    i_seen_count;
    logic [OWN_W-1:0]     i_own_count;
    logic [PEER_W-1:0]    i_active_peers;
    logic                 o_valid;
    logic                 i_ready;
    logic [IV_W-1:0]      o_interval_ms;
    logic [JIT_W-1:0]     o_jitter_ms;
    logic                 o_reset_radio;

    // Rate model state and register copies
    int unsigned  model_target;
    int unsigned  model_nominal;
    int unsigned  model_interval;
    logic [1:0]   model_silent;

    t_rate_result pending_results[$];
    int           error_count;
    int           stall_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           silent_burst;

    // Register settings per random phase; -1 picks a random value
    int phase_target  [PHASES] = '{0, 1023, 1, 16, 100, -1, 0, 1023, 20, 5, -1, 16};
    int phase_nominal [PHASES] = '{16, 1023, 1, 0, 1023, -1, 1023, 1, 64, 500, -1, 16};

    // Directed periods on the reset settings (target 16, nominal 16)
    t_period_row directed_rows [22] = '{
        // four silent periods in a row, the second with full own traffic
        '{'{12'd0,    12'd0,    8'd0},   1'b1, '{16'd1000, 14'd250,  1'b0}},
        '{'{12'd0,    12'd4095, 8'd255}, 1'b1, '{16'd1000, 14'd250,  1'b0}},
        '{'{12'd0,    12'd0,    8'd0},   1'b1, '{16'd1000, 14'd250,  1'b0}},
        '{'{12'd0,    12'd0,    8'd0},   1'b1, '{16'd1000, 14'd250,  1'b1}},
        // heavy load saturates at the ceiling
        '{'{12'd4095, 12'd4095, 8'd255}, 1'b1, '{16'd4000, 14'd1000, 1'b0}},
        '{'{12'd4095, 12'd0,    8'd0},   1'b1, '{16'd4000, 14'd1000, 1'b0}},
        // halving down to the floor, jitter minimum at the end
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd2000, 14'd500,  1'b0}},
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd1000, 14'd250,  1'b0}},
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd500,  14'd125,  1'b0}},
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd250,  14'd62,   1'b0}},
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd150,  14'd31,   1'b0}},
        '{'{12'd1,    12'd0,    8'd1},   1'b1, '{16'd150,  14'd25,   1'b0}},
        // trim band: per-peer minimum, no peers, zero share
        '{'{12'd8,    12'd0,    8'd1},   1'b0, '0},
        '{'{12'd8,    12'd0,    8'd0},   1'b0, '0},
        '{'{12'd8,    12'd0,    8'd255}, 1'b0, '0},
        // large trim, fine trim, own above seen
        '{'{12'd5,    12'd0,    8'd8},   1'b0, '0},
        '{'{12'd15,   12'd0,    8'd8},   1'b0, '0},
        '{'{12'd3,    12'd5,    8'd1},   1'b0, '0},
        // dead band, slow-down, silence after slow-down, traffic again
        '{'{12'd16,   12'd0,    8'd3},   1'b0, '0},
        '{'{12'd10,   12'd7,    8'd2},   1'b0, '0},
        '{'{12'd0,    12'd0,    8'd0},   1'b1, '{16'd1000, 14'd250,  1'b0}},
        '{'{12'd4095, 12'd4095, 8'd128}, 1'b0, '0}
    };

    channel_congestion_rate_control_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_seen_count   (i_seen_count),
        .i_own_count    (i_own_count),
        .i_active_peers (i_active_peers),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_interval_ms  (o_interval_ms),
        .o_jitter_ms    (o_jitter_ms),
        .o_reset_radio  (o_reset_radio)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Advance the interval model by one evaluation period
    task automatic step_rate_model(input t_traffic tr, output t_rate_result res);
        int unsigned     total;
        int unsigned     tgt;
        int unsigned     iv;
        int unsigned     adjust;
        int unsigned     minimum;
        int unsigned     share;
        int unsigned     jitter;
        longint unsigned ratio_q8;
        longint unsigned grown;
        logic            radio;
        total = tr.seen + tr.own;
        tgt   = model_target;
        iv    = model_interval;
        radio = 1'b0;
        // zero target counts as ratio one: no speed-up, no slow-down
        if (tgt != 0) begin
            if (100 * total < 95 * tgt) begin
                if (4 * total < tgt) begin
                    // halve with no per-peer minimum
                    iv = iv >> 1;
                end else begin
                    adjust = ADJ_BASE;
                    if (tr.peers == 0) begin
                        minimum = MIN_NO_PEER;
                    end else begin
                        share   = model_nominal / tr.peers;
                        minimum = (share == 0) ? MIN_SAT : IV_MAX / share;
                    end
                    if (5 * total < 4 * tgt && iv > TRIM_KNEE)
                        adjust = ADJ_MID;
                    if (2 * total < tgt && iv > TRIM_KNEE)
                        adjust = ADJ_BIG;
                    if (10 * total > 9 * tgt)
                        adjust = ADJ_FINE;
                    // skip the trim when we send more than we hear
                    if (tr.own <= tr.seen)
                        iv = (iv > adjust) ? iv - adjust : 0;
                    if (iv < minimum)
                        iv = minimum;
                end
            end else if (total > tgt) begin
                ratio_q8 = total;
                ratio_q8 = (ratio_q8 << 8) / tgt;
                grown    = (iv * (ratio_q8 + OFFSET_Q8)) >> 8;
                if (grown == 0)
                    grown = IV_ZERO;
                if (grown > IV_MAX)
                    grown = IV_MAX;
                iv = int'(grown);
            end
        end
        if (tr.seen == 0)
            iv = IV_SILENT;
        // jitter comes from the interval before the floor
        jitter = iv >> 2;
        if (jitter < JIT_MIN)
            jitter = JIT_MIN;
        if (iv < IV_FLOOR)
            iv = IV_FLOOR;
        if (tr.seen != 0) begin
            model_silent = 2'd0;
        end else if (model_silent == 2'd3) begin
            model_silent = 2'd0;
            radio        = 1'b1;
        end else begin
            model_silent = model_silent + 2'd1;
        end
        model_interval  = iv & 32'hFFFF;
        res.interval_ms = iv[IV_W-1:0];
        res.jitter_ms   = jitter[JIT_W-1:0];
        res.reset_radio = radio;
    endtask

    // Offer one period, wait for acceptance, record its expected result
    task automatic send_period(input t_traffic tr, input logic fixed, input t_rate_result want);
        t_rate_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_seen_count   <= tr.seen;
        i_own_count    <= tr.own;
        i_active_peers <= tr.peers;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        step_rate_model(tr, predicted);
        pending_results.push_back(fixed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TGT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TARGET:  model_target  = data;
            REG_NOMINAL: model_nominal = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Pick random traffic, mostly around the target ratio
    task automatic pick_traffic(output t_traffic tr);
        int unsigned span;
        int unsigned total;
        int unsigned own_part;
        int          roll;
        roll     = $urandom_range(99);
        tr.peers = ($urandom_range(3) == 0) ? PEER_W'($urandom_range(255))
                                            : PEER_W'($urandom_range(12));
        if (silent_burst == 0 && roll < 6)
            silent_burst = $urandom_range(5, 1);
        if (silent_burst > 0) begin
            // run of silent periods, long enough at times to request a reset
            silent_burst--;
            tr.seen = '0;
            tr.own  = ($urandom_range(1) == 0) ? OWN_W'($urandom_range(4095))
                                               : OWN_W'($urandom_range(20));
        end else if (roll < 18) begin
            tr.seen = SEEN_W'($urandom_range(4095));
            tr.own  = OWN_W'($urandom_range(4095));
        end else begin
            span     = (model_target == 0) ? 32 : model_target;
            total    = $urandom_range(span * 13 / 8 + 2, 1);
            own_part = $urandom_range(total - 1);
            if ($urandom_range(2) != 0)
                own_part = own_part / 4;
            tr.seen  = SEEN_W'(total - own_part);
            tr.own   = OWN_W'(own_part);
        end
    endtask

    // Randomly stall the result side
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_rate_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, interval", o_interval_ms, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_interval_ms !== want.interval_ms)
                    report_mismatch("interval_ms", o_interval_ms, want.interval_ms);
                if (o_jitter_ms !== want.jitter_ms)
                    report_mismatch("jitter_ms", o_jitter_ms, want.jitter_ms);
                if (o_reset_radio !== want.reset_radio)
                    report_mismatch("reset_radio", o_reset_radio, want.reset_radio);
            end
        end
    end

    // End the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("channel_congestion_rate_control_top_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        t_traffic     tr;
        t_rate_result none;
        int           tgt;
        int           nom;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_seen_count   = '0;
        i_own_count    = '0;
        i_active_peers = '0;
        i_ready        = 1'b0;
        error_count    = 0;
        stall_cycles   = 0;
        silent_burst   = 0;
        none           = '0;
        send_idle_pct  = 34;
        recv_idle_pct  = 58;
        // reset values of the registers and state
        model_target   = TGT_RESET;
        model_nominal  = TGT_RESET;
        model_interval = IV_SILENT;
        model_silent   = 2'd0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table on the reset settings
        foreach (directed_rows[i])
            send_period(directed_rows[i].traffic, directed_rows[i].fixed, directed_rows[i].want);
        i_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            // idling pattern: sender light, then receiver light, then none
            if (ph < 4) begin
                send_idle_pct = 34;
                recv_idle_pct = 58;
            end else if (ph < 8) begin
                send_idle_pct = 58;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // drain before touching the registers
            while (pending_results.size() != 0) @(negedge i_clk);
            tgt = (phase_target[ph] < 0) ? $urandom_range(1023) : phase_target[ph];
            nom = (phase_nominal[ph] < 0) ? $urandom_range(1023) : phase_nominal[ph];
            write_register((ph % 2 == 0) ? REG_SPARE_A : REG_SPARE_B,
                           TGT_W'($urandom_range(1023)));
            write_register(REG_TARGET, TGT_W'(tgt));
            write_register(REG_NOMINAL, TGT_W'(nom));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick_traffic(tr);
                send_period(tr, 1'b0, none);
            end
            i_valid <= 1'b0;
        end

        // Drain and let any stray result show up
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("channel_congestion_rate_control_top_tb: done, clean");
        else
            $display("channel_congestion_rate_control_top_tb: done, errors");
        $finish;
    end

endmodule
